// File: rtl/hlfe_pkg.sv
package hlfe_pkg;

  localparam int FrameDepth = 64;
  localparam int AddrW      = $clog2(FrameDepth);
  localparam int ByteW      = 8;
  localparam int LenW       = 7;
  localparam int MinLen     = 3;
  localparam int CfgIdxW    = 2;

  localparam logic [ByteW-1:0] StartOneRst = 8'hFC;
  localparam logic [ByteW-1:0] StartTwoRst = 8'h01;
  localparam logic [LenW-1:0]  MaxLenRst   = 7'd64;
  localparam logic [LenW-1:0]  DepthLen    = LenW'(FrameDepth);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_ONE = 2'd0,
    CFG_START_TWO = 2'd1,
    CFG_MAX_LEN   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_HUNT_ONE = 4'b0001,
    PH_HUNT_TWO = 4'b0010,
    PH_LENGTH   = 4'b0100,
    PH_FILL     = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    EM_IDLE  = 3'b001,
    EM_PRIME = 3'b010,
    EM_SEND  = 3'b100
  } emit_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic            valid;
    logic [LenW-1:0] len;
  } frame_start_t;

endpackage

// File: rtl/hlfe_store.sv
module hlfe_store import hlfe_pkg::*; (
  input  logic             clk_i,
  input  ram_wr_t          wr_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem [FrameDepth];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/hlfe_framer.sv
module hlfe_framer import hlfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] start_one_i,
  input  logic [ByteW-1:0] start_two_i,
  input  logic [LenW-1:0]  max_len_i,
  output ram_wr_t          wr_o,
  output frame_start_t     start_o
);

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] exp_len_q, exp_len_d;
  logic [LenW-1:0] fill_q, fill_d;
  logic [LenW-1:0] fill_next;
  logic            is_one;
  logic            bad_len;

  assign is_one    = (byte_i == start_one_i);
  assign bad_len   = (byte_i < ByteW'(MinLen)) || (byte_i > {1'b0, max_len_i});
  assign fill_next = fill_q + LenW'(1);

  always_comb begin
    phase_d       = phase_q;
    exp_len_d     = exp_len_q;
    fill_d        = fill_q;
    wr_o.en       = 1'b0;
    wr_o.addr     = '0;
    wr_o.data     = byte_i;
    start_o.valid = 1'b0;
    start_o.len   = exp_len_q;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT_TWO: begin
          if (byte_i == start_two_i) begin
            wr_o.en   = 1'b1;
            wr_o.addr = AddrW'(1);
            phase_d   = PH_LENGTH;
          end else begin
            wr_o.en = is_one;
            phase_d = is_one ? PH_HUNT_TWO : PH_HUNT_ONE;
          end
        end
        PH_LENGTH: begin
          if (bad_len) begin
            wr_o.en = is_one;
            phase_d = is_one ? PH_HUNT_TWO : PH_HUNT_ONE;
          end else begin
            wr_o.en   = 1'b1;
            wr_o.addr = AddrW'(2);
            exp_len_d = byte_i[LenW-1:0];
            if (byte_i == ByteW'(MinLen)) begin
              start_o.valid = 1'b1;
              start_o.len   = byte_i[LenW-1:0];
              fill_d        = '0;
              phase_d       = PH_HUNT_ONE;
            end else begin
              fill_d  = LenW'(MinLen);
              phase_d = PH_FILL;
            end
          end
        end
        PH_FILL: begin
          wr_o.en   = 1'b1;
          wr_o.addr = fill_q[AddrW-1:0];
          if (fill_next >= exp_len_q) begin
            start_o.valid = 1'b1;
            fill_d        = '0;
            phase_d       = PH_HUNT_ONE;
          end else begin
            fill_d = fill_next;
          end
        end
        default: begin
          wr_o.en = is_one;
          phase_d = is_one ? PH_HUNT_TWO : PH_HUNT_ONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT_ONE;
      exp_len_q <= '0;
      fill_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      fill_q    <= fill_d;
    end
  end

endmodule

// File: rtl/hlfe_emitter.sv
module hlfe_emitter import hlfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frame_start_t     start_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             busy_o,
  output logic [AddrW-1:0] rd_addr_o,
  output logic [AddrW-1:0] pos_o,
  output logic [LenW-1:0]  len_o,
  output logic             last_o
);

  emit_e            state_q, state_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             last;
  logic             fire;

  assign last  = ({1'b0, pos_q} + LenW'(1)) == len_q;
  assign fire  = (state_q == EM_SEND) && out_ready_i;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    len_d   = len_q;
    case (state_q)
      EM_IDLE: begin
        if (start_i.valid) begin
          len_d   = start_i.len;
          pos_d   = '0;
          state_d = EM_PRIME;
        end
      end
      EM_PRIME: begin
        state_d = EM_SEND;
      end
      EM_SEND: begin
        if (fire) begin
          if (last) begin
            state_d = EM_IDLE;
          end else begin
            pos_d = pos_q + AddrW'(1);
          end
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
    end
  end

  // hold the read address under stall so the RAM output stays stable
  assign rd_addr_o   = pos_d;
  assign out_valid_o = (state_q == EM_SEND);
  assign busy_o      = (state_q != EM_IDLE);
  assign pos_o       = pos_q;
  assign len_o       = len_q;
  assign last_o      = last;

endmodule

// File: rtl/header_length_frame_extractor.sv
// Input: one byte per cycle while hunting, reading the length or filling a frame.
// The frame is emitted after its closing byte transfers, via emitter states PRIME (RAM read)
// then SEND: one byte per cycle from the frame RAM read port, while m_axis_tready is high.
// Input is stalled from frame completion until the last frame byte transfers.
// Reset: async active low; config returns to defaults, framer and emitter return to idle.
// The frame RAM is not cleared; every entry is written before it is read.
module header_length_frame_extractor import hlfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_position,
                                             // [20:14] frame_length, [23:21] zero
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  logic [ByteW-1:0] start_one_q;
  logic [ByteW-1:0] start_two_q;
  logic [LenW-1:0]  max_len_q;
  logic [LenW-1:0]  eff_max;
  logic             in_accept;
  logic             busy;
  ram_wr_t          ram_wr;
  frame_start_t     frame_start;
  logic [AddrW-1:0] rd_addr;
  logic [ByteW-1:0] rd_data;
  logic [AddrW-1:0] pos;
  logic [LenW-1:0]  len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_one_q <= StartOneRst;
      start_two_q <= StartTwoRst;
      max_len_q   <= MaxLenRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_ONE: start_one_q <= cfg_data_i;
        CFG_START_TWO: start_two_q <= cfg_data_i;
        CFG_MAX_LEN:   max_len_q   <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign eff_max       = (max_len_q > DepthLen) ? DepthLen : max_len_q;
  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  hlfe_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .byte_i      (s_axis_tdata),
    .start_one_i (start_one_q),
    .start_two_i (start_two_q),
    .max_len_i   (eff_max),
    .wr_o        (ram_wr),
    .start_o     (frame_start)
  );

  hlfe_store u_store (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  hlfe_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (frame_start),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .busy_o      (busy),
    .rd_addr_o   (rd_addr),
    .pos_o       (pos),
    .len_o       (len),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, len, pos, rd_data};

endmodule
